>>> rtl/core/pixel_hit_clusterer_core_macros.svh
// Assertion macros for the pixel hit clusterer core.
`ifndef PIXEL_HIT_CLUSTERER_CORE_MACROS_SVH
`define PIXEL_HIT_CLUSTERER_CORE_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define PXC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pixel hit clusterer check failed");
// Consequent must hold in the cycle after the antecedent.
`define PXC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pixel hit clusterer check failed");
`else
`define PXC_ASSERT_NOW(lbl, ante, cons)
`define PXC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/pxc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel hit clusterer package
// Shared widths, payload types, control structs and helper functions.
// ----------------------------------------------------------------------------
package pxc_pkg;

   // Cluster geometry and field widths.
   localparam int SLOTS    = 8;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int CHIP_W   = 4;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 9;
   localparam int SUM_W    = COL_W + IDX_W;
   localparam int DVD_W    = SUM_W + 1;
   localparam int QUO_W    = COL_W + 1;
   localparam int STEP_W   = $clog2(QUO_W + 1);
   localparam int WORD_W   = 30;
   localparam int NFIELD_W = 4;

   typedef logic [SLOTS-1:0] mask_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic              is_header;
      logic [CHIP_W-1:0] chip_id;
      logic [COL_W-1:0]  pixel_column;
      logic [ROW_W-1:0]  pixel_row;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } pix_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic apply_hit;
      logic start_sum;
      logic div_start;
      logic load_flush;
      logic load_echo;
      logic flush_last;
      logic shift;
      logic place_hit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic flush_req;
      logic c0_empty;
      logic div_busy;
      logic out_free;
   } sts_type;

   // Number of set bits in a slot mask.
   function automatic cnt_type count_ones(input mask_type m);
      cnt_type n;
      n = '0;
      for (int i = 0; i < SLOTS; i++) begin
         n = n + cnt_type'(m[i]);
      end
      return n;
   endfunction

   // Mask with the k lowest slots set.
   function automatic mask_type thermo(input logic [CNT_W:0] k);
      mask_type m;
      for (int i = 0; i < SLOTS; i++) begin
         m[i] = ((CNT_W+1)'(i) < k);
      end
      return m;
   endfunction

endpackage

>>> rtl/core/pxc_div.sv
// ----------------------------------------------------------------------------
// Pixel hit clusterer divider
// Two-lane restoring divider sharing one small divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pxc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  pxc_pkg::cnt_type            divisor,
   input  logic [pxc_pkg::DVD_W-1:0]   dvd_a,
   input  logic [pxc_pkg::DVD_W-1:0]   dvd_b,
   output logic                        busy,
   output logic [pxc_pkg::QUO_W-1:0]   quo_a,
   output logic [pxc_pkg::QUO_W-1:0]   quo_b
);
   import pxc_pkg::*;

   cnt_type             rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [QUO_W-1:0]    sh_a_ff, sh_a_in, sh_b_ff, sh_b_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                bit_a, bit_b;
   cnt_type             nrem_a, nrem_b;

   // One restoring step: returns the new remainder and sets the quotient bit.
   function automatic cnt_type div_step(input cnt_type rem, input logic nb,
                                        input cnt_type d, output logic qb);
      logic [CNT_W:0] trial;
      logic [CNT_W:0] diff;
      trial = {rem, nb};
      diff  = trial - {1'b0, d};
      qb    = (trial >= {1'b0, d});
      return qb ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   endfunction

   always_comb begin
      nrem_a = div_step(rem_a_ff, sh_a_ff[QUO_W-1], divisor, bit_a);
      nrem_b = div_step(rem_b_ff, sh_b_ff[QUO_W-1], divisor, bit_b);
   end

   // The upper dividend bits are known to be below the divisor, so only
   // the quotient bits that can be nonzero are iterated.
   always_comb begin
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      sh_a_in  = sh_a_ff;
      sh_b_in  = sh_b_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_a_in = CNT_W'(dvd_a[DVD_W-1:QUO_W]);
         rem_b_in = CNT_W'(dvd_b[DVD_W-1:QUO_W]);
         sh_a_in  = dvd_a[QUO_W-1:0];
         sh_b_in  = dvd_b[QUO_W-1:0];
         step_in  = STEP_W'(QUO_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_a_in = nrem_a;
         rem_b_in = nrem_b;
         sh_a_in  = {sh_a_ff[QUO_W-2:0], bit_a};
         sh_b_in  = {sh_b_ff[QUO_W-2:0], bit_b};
         step_in  = step_ff - STEP_W'(1);
         busy_in  = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      sh_a_ff  <= sh_a_in;
      sh_b_ff  <= sh_b_in;
   end

   assign busy  = busy_ff;
   assign quo_a = sh_a_ff;
   assign quo_b = sh_b_ff;

endmodule

>>> rtl/core/pxc_dp.sv
// ----------------------------------------------------------------------------
// Pixel hit clusterer datapath
// Cluster slot registers, neighbor search, merge, centroid sums and output.
// ----------------------------------------------------------------------------
module pxc_dp (
   input  logic              clock,
   input  logic              reset,
   input  pxc_pkg::cmd_type  cmd,
   output pxc_pkg::sts_type  sts,
   input  pxc_pkg::req_type  req_data,
   output pxc_pkg::rsp_type  rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready
);
   import pxc_pkg::*;

   req_type                 req_ff, req_in;
   logic [CHIP_W-1:0]       chip_ff, chip_in;
   pix_type [SLOTS-1:0]     st0_ff, st0_in, st1_ff, st1_in;
   mask_type                mask0_ff, mask0_in, mask1_ff, mask1_in;
   logic [SUM_W-1:0]        sum_col_ff, sum_col_in, sum_row_ff, sum_row_in;
   cnt_type                 n_ff, n_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   pix_type                 hit;
   mask_type                near0_vec, near1_vec;
   cnt_type                 n0, n1;
   logic                    e0, e1, add0, add1, merge, fits;
   logic [CNT_W:0]          total;
   logic [SUM_W-1:0]        sum_c, sum_r;
   logic [DVD_W-1:0]        dvd_c, dvd_r;
   logic [QUO_W-1:0]        quo_c, quo_r;
   logic                    div_busy;
   logic [CNT_W:0]          off;
   logic [WORD_W-1:0]       flush_word;

   // True when two pixels are at most one column and one row apart.
   function automatic logic adjacent(input pix_type a, input pix_type b);
      logic [COL_W:0] ac, bc;
      logic [ROW_W:0] ar, br;
      ac = {1'b0, a.col};
      bc = {1'b0, b.col};
      ar = {1'b0, a.row};
      br = {1'b0, b.row};
      return ((ac == bc) || (ac == bc + 1'b1) || (bc == ac + 1'b1)) &&
             ((ar == br) || (ar == br + 1'b1) || (br == ar + 1'b1));
   endfunction

   assign hit = pix_type'{req_ff.pixel_column, req_ff.pixel_row};

   // Neighbor search over every valid slot of both clusters.
   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         near0_vec[j] = mask0_ff[j] && adjacent(hit, st0_ff[j]);
         near1_vec[j] = mask1_ff[j] && adjacent(hit, st1_ff[j]);
      end
   end

   // Join decisions; slots fill from the bottom, so a count is a slot index.
   always_comb begin
      n0    = count_ones(mask0_ff);
      n1    = count_ones(mask1_ff);
      e0    = (mask0_ff == '0);
      e1    = (mask1_ff == '0);
      add0  = e0 || ((near0_vec != '0) && !mask0_ff[SLOTS-1]);
      add1  = !e0 && (e1 ? !add0 : ((near1_vec != '0) && !mask1_ff[SLOTS-1]));
      merge = add0 && add1;
      total = (CNT_W+1)'(n0) + (CNT_W+1)'(n1) + (CNT_W+1)'(1);
      fits  = (total <= (CNT_W+1)'(SLOTS));
   end

   // Coordinate sums over the valid slots of the older cluster.
   always_comb begin
      sum_c = '0;
      sum_r = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (mask0_ff[j]) begin
            sum_c = sum_c + SUM_W'(st0_ff[j].col);
            sum_r = sum_r + SUM_W'(st0_ff[j].row);
         end
      end
   end

   // Half-pixel centroid: (2*sum + n) / n for each axis.
   assign dvd_c = {sum_col_ff, 1'b0} + DVD_W'(n_ff);
   assign dvd_r = {sum_row_ff, 1'b0} + DVD_W'(n_ff);

   pxc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .divisor (n_ff),
      .dvd_a   (dvd_c),
      .dvd_b   (dvd_r),
      .busy    (div_busy),
      .quo_a   (quo_c),
      .quo_b   (quo_r)
   );

   assign flush_word = {NFIELD_W'(n_ff), chip_ff, 1'b0, quo_c, quo_r[ROW_W:0]};

   // Next-state logic for cluster storage and the output register.
   always_comb begin
      req_in       = req_ff;
      chip_in      = chip_ff;
      st0_in       = st0_ff;
      st1_in       = st1_ff;
      mask0_in     = mask0_ff;
      mask1_in     = mask1_ff;
      sum_col_in   = sum_col_ff;
      sum_row_in   = sum_row_ff;
      n_in         = n_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      off          = '0;

      if (cmd.load_req) begin
         req_in = req_data;
      end

      // Hit update: join, start a cluster, or merge the two clusters.
      if (cmd.apply_hit) begin
         chip_in = req_ff.chip_id;
         if (add0) begin
            for (int j = 0; j < SLOTS; j++) begin
               off = (CNT_W+1)'(j) - (CNT_W+1)'(n0) - (CNT_W+1)'(1);
               if (CNT_W'(j) == n0) begin
                  st0_in[j] = hit;
               end else if (merge && fits && (CNT_W'(j) > n0)) begin
                  st0_in[j] = st1_ff[off[IDX_W-1:0]];
               end
            end
            if (merge && fits) begin
               mask0_in = thermo(total);
            end else begin
               mask0_in = mask0_ff | (mask_type'(1) << n0);
            end
         end
         if (add1 && !add0) begin
            st1_in[n1[IDX_W-1:0]] = hit;
            mask1_in = mask1_ff | (mask_type'(1) << n1);
         end
         if (merge && fits) begin
            mask1_in = '0;
         end
      end

      if (cmd.start_sum) begin
         sum_col_in = sum_c;
         sum_row_in = sum_r;
         n_in       = n0;
      end

      // After a flush the newer cluster becomes the older one.
      if (cmd.shift) begin
         st0_in   = st1_ff;
         mask0_in = mask1_ff;
         mask1_in = '0;
      end
      if (cmd.place_hit) begin
         st1_in[0] = hit;
         mask1_in  = mask1_in | mask_type'(1);
      end

      // Output register.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_flush) begin
         rsp_in       = rsp_type'{flush_word, cmd.flush_last};
         rsp_valid_in = 1'b1;
      end
      if (cmd.load_echo) begin
         rsp_in = rsp_type'{WORD_W'({req_ff.chip_id, 1'b1, req_ff.pixel_column,
                                     req_ff.pixel_row, 2'b00}), 1'b1};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff      <= '0;
         mask0_ff     <= '0;
         mask1_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chip_ff      <= chip_in;
         mask0_ff     <= mask0_in;
         mask1_ff     <= mask1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      st0_ff     <= st0_in;
      st1_ff     <= st1_in;
      sum_col_ff <= sum_col_in;
      sum_row_ff <= sum_row_in;
      n_ff       <= n_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.flush_req = !add0 && !add1;
   assign sts.c0_empty  = e0;
   assign sts.div_busy  = div_busy;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_data      = rsp_ff;
   assign rsp_valid     = rsp_valid_ff;

endmodule

>>> rtl/core/pxc_ctrl.sv
// ----------------------------------------------------------------------------
// Pixel hit clusterer controller
// Sequences hit updates, cluster flushes and header echoes.
// ----------------------------------------------------------------------------
module pxc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_is_header,
   output logic              req_ready,
   input  pxc_pkg::sts_type  sts,
   output pxc_pkg::cmd_type  cmd
);
   import pxc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_HIT   = 7'b0000010,
      ST_SUM   = 7'b0000100,
      ST_START = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_ECHO  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      hdr_ff, hdr_in;
   logic      pass_ff, pass_in;

   always_comb begin
      state_in  = state_ff;
      hdr_in    = hdr_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               hdr_in       = req_is_header;
               pass_in      = 1'b0;
               state_in     = req_is_header ? ST_SUM : ST_HIT;
            end
         end
         ST_HIT: begin
            cmd.apply_hit = 1'b1;
            state_in      = sts.flush_req ? ST_SUM : ST_IDLE;
         end
         // An empty older cluster gives no result and no shift.
         ST_SUM: begin
            if (!sts.c0_empty) begin
               cmd.start_sum = 1'b1;
               state_in      = ST_START;
            end else if (!hdr_ff) begin
               cmd.place_hit = 1'b1;
               state_in      = ST_IDLE;
            end else if (!pass_ff) begin
               pass_in  = 1'b1;
               state_in = ST_SUM;
            end else begin
               state_in = ST_ECHO;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         // Emit the cluster and shift together; a hit that joined nothing moves in.
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_flush = 1'b1;
               cmd.flush_last = !hdr_ff;
               cmd.shift      = 1'b1;
               cmd.place_hit  = !hdr_ff;
               if (!hdr_ff) begin
                  state_in = ST_IDLE;
               end else if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_ECHO;
               end
            end
         end
         ST_ECHO: begin
            if (sts.out_free) begin
               cmd.load_echo = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hdr_ff   <= 1'b0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hdr_ff   <= hdr_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

>>> rtl/core/pixel_hit_clusterer_core.sv
// ----------------------------------------------------------------------------
// Pixel hit clusterer core
// Groups pixel hits into two open clusters and reports cluster centroids.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: a header or a pixel hit.
//   rsp_* returns result items; last_of_run marks the final result of an
//   input item. A hit gives zero or one result, a header one to three.
//   Steps per input item:
//     hit that joins a cluster: accept, cluster update.
//     hit that flushes: accept, cluster update, sum, divider start,
//       divide, then emit the result.
//     header: accept, two flush passes (a pass ends at once when the
//       older cluster is empty), and the echo.
//   Each flush waits for the centroid divider, which resolves one quotient
//   bit per cycle, column and row in parallel.
//   One item is in work at a time; req_ready is high only between items.
//   Results sit in an output register; while the receiver stalls, the
//   controller holds before loading the next result.
//   Reset empties both clusters, clears the stored chip and drops any
//   pending result.
// ----------------------------------------------------------------------------
`include "pixel_hit_clusterer_core_macros.svh"

module pixel_hit_clusterer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pxc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pxc_pkg::rsp_type  rsp_data
);
   import pxc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pxc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_is_header (req_data.is_header),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   pxc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   // An accepted item keeps the input closed for at least the next cycle.
   `PXC_ASSERT_NEXT(a_accept_closes, req_valid && req_ready, !req_ready)
   // A result is loaded only when the output register can take it.
   `PXC_ASSERT_NOW(a_load_when_free, cmd.load_flush || cmd.load_echo, sts.out_free)
   // The divider is busy right after it is started.
   `PXC_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy)

endmodule

>>> tb/sv/tb_pixel_hit_clusterer_core.sv
// ----------------------------------------------------------------------------
// Pixel hit clusterer core testbench
// Drives headers and pixel hits through the request channel, predicts the
// cluster and header results with a cycle-free model of the two open
// clusters, and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_pixel_hit_clusterer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pxc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pixel_hit_clusterer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predictor state: two open clusters and the chip of the latest hit.
   pix_type  clu_pix [2][SLOTS];
   mask_type clu_mask [2];
   logic [CHIP_W-1:0] last_chip;

   req_type pending_items[$];
   rsp_type expected_results[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      stim_done = 1'b0;
   int      hold_off = 0;
   int      long_stall_left = 0;

   function automatic int pop_count(input mask_type m);
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += m[i];
      return n;
   endfunction

   // Report cluster 0 and move cluster 1 down; nothing happens when empty.
   task automatic flush_oldest();
      int n, sc, sr, hc, hr;
      rsp_type r;
      n = 0; sc = 0; sr = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (clu_mask[0][i]) begin
            n++;
            sc += clu_pix[0][i].col;
            sr += clu_pix[0][i].row;
         end
      end
      if (n == 0) return;
      hc = (2 * sc + n) / n;
      hr = (2 * sr + n) / n;
      r.result_word = '0;
      r.result_word[29:26] = n[3:0];
      r.result_word[25:22] = last_chip;
      r.result_word[20:11] = hc[10:1];
      r.result_word[10]    = hc[0];
      r.result_word[9:1]   = hr[9:1];
      r.result_word[0]     = hr[0];
      r.last_of_run = 1'b0;
      expected_results.push_back(r);
      clu_pix[0]  = clu_pix[1];
      clu_mask[0] = clu_mask[1];
      clu_mask[1] = '0;
   endtask

   // Work out the results of one accepted item and append them.
   task automatic predict_clusters(input req_type it);
      int      first, n0, n1;
      bit      added[2];
      bit      near;
      int      dc, dr;
      pix_type hit;
      rsp_type r;
      first = expected_results.size();
      hit.col = it.pixel_column;
      hit.row = it.pixel_row;
      added[0] = 0; added[1] = 0;
      if (it.is_header) begin
         flush_oldest();
         flush_oldest();
         r.result_word = {4'b0, it.chip_id, 1'b1, it.pixel_column, it.pixel_row, 2'b00};
         r.last_of_run = 1'b1;
         expected_results.push_back(r);
         return;
      end
      last_chip = it.chip_id;
      for (int c = 0; c < 2; c++) begin
         near = 0;
         if (clu_mask[c] == '0) begin
            if (!added[0]) begin
               clu_pix[c][0] = hit;
               clu_mask[c] = 1;
               added[c] = 1;
            end
            break;
         end
         for (int p = 0; p < SLOTS; p++) begin
            if (!clu_mask[c][p]) begin
               if (near) begin
                  clu_pix[c][p] = hit;
                  clu_mask[c][p] = 1'b1;
                  added[c] = 1;
               end
               break;
            end
            dc = int'(hit.col) - int'(clu_pix[c][p].col);
            dr = int'(hit.row) - int'(clu_pix[c][p].row);
            if (dc >= -1 && dc <= 1 && dr >= -1 && dr <= 1) near = 1;
         end
      end
      if (added[0] && added[1]) begin
         // The shared hit sits in the newest slot of cluster 1; drop it first.
         n0 = pop_count(clu_mask[0]);
         n1 = pop_count(clu_mask[1]);
         clu_mask[1][n1-1] = 1'b0;
         if (n0 + n1 - 1 <= SLOTS) begin
            for (int i = 0; i + 1 < n1; i++) begin
               clu_pix[0][n0+i] = clu_pix[1][i];
               clu_mask[0][n0+i] = 1'b1;
            end
            clu_mask[1] = '0;
         end
      end else if (!added[0] && !added[1]) begin
         flush_oldest();
         clu_pix[1][0] = hit;
         clu_mask[1][0] = 1'b1;
      end
      if (expected_results.size() > first)
         expected_results[expected_results.size()-1].last_of_run = 1'b1;
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Driver: offers queued items with random gaps between them.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_clusters(req_data);
            hold_off = gap_len();
         end
         if ((req_valid && !req_ready)) begin
            // Keep offering the same item.
         end else if (hold_off > 0) begin
            hold_off--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            stim_done = 1'b1;
         end
      end
   end

   // Monitor: checks result items and drives ready with random stalls.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item %h", rsp_data);
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_data.result_word !== exp_r.result_word) begin
                  $error("result_word expected %h actual %h",
                         exp_r.result_word, rsp_data.result_word);
                  error_count++;
               end
               if (rsp_data.last_of_run !== exp_r.last_of_run) begin
                  $error("last_of_run expected %b actual %b",
                         exp_r.last_of_run, rsp_data.last_of_run);
                  error_count++;
               end
            end
         end
         if (cycle_count == 3000) long_stall_left = 400;
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0) ||
                         (cycle_count % 2000 > 1500);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type make_hit(input int chip, input int col, input int row);
      req_type it;
      it.is_header    = 1'b0;
      it.chip_id      = chip[CHIP_W-1:0];
      it.pixel_column = col[COL_W-1:0];
      it.pixel_row    = row[ROW_W-1:0];
      return it;
   endfunction

   function automatic req_type make_header(input int chip, input int col, input int row);
      req_type it;
      it = make_hit(chip, col, row);
      it.is_header = 1'b1;
      return it;
   endfunction

   // A compact blob of hits near a random center, in random order.
   task automatic add_blob();
      int n, cc, cr;
      n  = $urandom_range(1, 10);
      cc = $urandom_range(0, 1023);
      cr = $urandom_range(0, 511);
      for (int i = 0; i < n; i++) begin
         pending_items.push_back(make_hit($urandom_range(0, 15),
            (cc + $urandom_range(0, 3)) % 1024, (cr + $urandom_range(0, 3)) % 512));
      end
   endtask

   initial begin
      int total;
      for (int c = 0; c < 2; c++) clu_mask[c] = '0;
      last_chip = '0;

      // Header on an empty block, extremes of the fields.
      pending_items.push_back(make_header(0, 0, 0));
      pending_items.push_back(make_header(15, 1023, 511));
      pending_items.push_back(make_hit(15, 1023, 511));
      pending_items.push_back(make_hit(3, 1022, 510));
      pending_items.push_back(make_hit(0, 0, 0));
      pending_items.push_back(make_hit(1, 1, 1));
      // Full cluster: nine neighbours in a line; the ninth cannot join.
      for (int i = 0; i < 9; i++) pending_items.push_back(make_hit(5, 100, 200 + (i % 2)));
      // Hit joining both clusters causes a merge.
      pending_items.push_back(make_header(2, 5, 5));
      pending_items.push_back(make_hit(7, 10, 10));
      pending_items.push_back(make_hit(7, 12, 10));
      pending_items.push_back(make_hit(7, 11, 10));
      pending_items.push_back(make_hit(7, 300, 300));
      pending_items.push_back(make_header(9, 512, 256));
      pending_items.push_back(make_header(6, 700, 100));

      total = pending_items.size();
      while (total < 480) begin
         case ($urandom_range(0, 9))
            0:       pending_items.push_back(make_header($urandom_range(0, 15),
                        $urandom_range(0, 1023), $urandom_range(0, 511)));
            1:       pending_items.push_back(make_hit($urandom_range(0, 15),
                        $urandom_range(0, 1023), $urandom_range(0, 511)));
            default: add_blob();
         endcase
         total = pending_items.size();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (stim_done && expected_results.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
